// File: src/pct_pkg.sv
// Shared constants, codes and types of the packed component table.
package pct_pkg;

   // Table dimensions
   localparam int MAX_ENTITIES = 1024;
   localparam int CAPACITY     = 256;
   localparam int PAYLOAD_BITS = 32;

   // Derived widths
   localparam int ENT_AW  = $clog2(MAX_ENTITIES);
   localparam int SLOT_AW = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int MAP_W   = SLOT_AW + 1;   // valid mark over slot number

   // Command codes
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_GET    = 2'd2
   } cmd_type;

   // Status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_PRESENT   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_GET,
      S_MOVE,
      S_DROP
   } state_type;

endpackage

// File: src/pct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/packed_component_table.sv
// Packed component table; insert steps: LOOKUP; get: LOOKUP, GET; remove: LOOKUP, MOVE, DROP.
// The result word shows in the cycle after the last step; busy falls in that same cycle, so
// a new word may start then. One word at a time; the entity map's single port sets the pace.
// After reset a clearing pass writes every entity map entry (MAX_ENTITIES of them, 1024),
// with busy high. Results cannot be stalled: each is shown for one cycle under rsp_strobe.
module packed_component_table
   import pct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_command,
   input  logic [ENT_AW-1:0]       req_entity_id,
   input  logic [PAYLOAD_BITS-1:0] req_payload_in,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic [PAYLOAD_BITS-1:0] rsp_payload_out,
   output logic [SLOT_AW-1:0]      rsp_dense_slot,
   output logic [CNT_W-1:0]        rsp_live_count
);

   // control registers
   state_type          state_ff, state_in;
   logic [ENT_AW-1:0]  clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   // word held while it is worked on
   cmd_type                 cmd_ff, cmd_in;
   logic [ENT_AW-1:0]       ent_ff, ent_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [SLOT_AW-1:0]      slot_ff, slot_in;

   // result registers
   status_type              rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_BITS-1:0] rsp_payload_ff, rsp_payload_in;
   logic [SLOT_AW-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   // memory ports
   logic                    map_we;
   logic [ENT_AW-1:0]       map_wa, map_ra;
   logic [MAP_W-1:0]        map_wd, map_rd;
   logic                    eos_we;
   logic [SLOT_AW-1:0]      eos_wa, eos_ra;
   logic [ENT_AW-1:0]       eos_wd, eos_rd;
   logic                    pl_we;
   logic [SLOT_AW-1:0]      pl_wa, pl_ra;
   logic [PAYLOAD_BITS-1:0] pl_wd, pl_rd;

   logic                    map_valid;
   logic [SLOT_AW-1:0]      map_slot;
   logic [SLOT_AW-1:0]      last_slot;

   // entity map: valid mark and slot per entity
   pct_ram #(.WIDTH(MAP_W), .DEPTH(MAX_ENTITIES)) u_entity_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_addr (map_ra),
      .rd_data (map_rd)
   );

   // slot map: owning entity per slot
   pct_ram #(.WIDTH(ENT_AW), .DEPTH(CAPACITY)) u_slot_map (
      .clock   (clock),
      .wr_en   (eos_we),
      .wr_addr (eos_wa),
      .wr_data (eos_wd),
      .rd_addr (eos_ra),
      .rd_data (eos_rd)
   );

   // dense payload array
   pct_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(CAPACITY)) u_payload (
      .clock   (clock),
      .wr_en   (pl_we),
      .wr_addr (pl_wa),
      .wr_data (pl_wd),
      .rd_addr (pl_ra),
      .rd_data (pl_rd)
   );

   assign map_valid = map_rd[SLOT_AW];
   assign map_slot  = map_rd[SLOT_AW-1:0];
   assign last_slot = SLOT_AW'(count_ff - CNT_W'(1));

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      ent_ff         <= ent_in;
      pay_ff         <= pay_in;
      slot_ff        <= slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // sequencer: next state, memory controls and result word
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      count_in       = count_ff;
      cmd_in         = cmd_ff;
      ent_in         = ent_ff;
      pay_in         = pay_ff;
      slot_in        = slot_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_count_in   = rsp_count_ff;

      map_we = 1'b0;
      map_wa = ent_ff;
      map_wd = '0;
      map_ra = req_entity_id;
      eos_we = 1'b0;
      eos_wa = slot_ff;
      eos_wd = ent_ff;
      eos_ra = last_slot;
      pl_we  = 1'b0;
      pl_wa  = slot_ff;
      pl_wd  = pay_ff;
      pl_ra  = (cmd_ff == CMD_GET) ? map_slot : last_slot;

      case (state_ff)
         // clear every valid mark after reset
         S_CLEAR: begin
            map_we      = 1'b1;
            map_wa      = clr_addr_ff;
            map_wd      = '0;
            clr_addr_in = clr_addr_ff + ENT_AW'(1);
            if (clr_addr_ff == ENT_AW'(MAX_ENTITIES - 1)) begin
               state_in = S_IDLE;
            end
         end

         // take a word; entity map read is launched from the request ports
         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(req_command);
               ent_in   = req_entity_id;
               pay_in   = req_payload_in;
               state_in = S_LOOKUP;
            end
         end

         // entity map data is back: decide the command
         S_LOOKUP: begin
            rsp_payload_in = '0;
            rsp_slot_in    = '0;
            rsp_count_in   = count_ff;
            rsp_status_in  = ST_OK;
            state_in       = S_IDLE;
            case (cmd_ff)
               CMD_INSERT: begin
                  rsp_strobe_in = 1'b1;
                  if (map_valid) begin
                     rsp_status_in = ST_PRESENT;
                     rsp_slot_in   = map_slot;
                  end else if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     map_we       = 1'b1;
                     map_wd       = {1'b1, SLOT_AW'(count_ff)};
                     eos_we       = 1'b1;
                     eos_wa       = SLOT_AW'(count_ff);
                     pl_we        = 1'b1;
                     pl_wa        = SLOT_AW'(count_ff);
                     count_in     = count_ff + CNT_W'(1);
                     rsp_slot_in  = SLOT_AW'(count_ff);
                     rsp_count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_REMOVE, CMD_GET: begin
                  if (!map_valid || ({1'b0, map_slot} >= count_ff)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_NOT_FOUND;
                  end else begin
                     slot_in  = map_slot;
                     state_in = (cmd_ff == CMD_GET) ? S_GET : S_MOVE;
                  end
               end
               default: begin
                  // unused command: no change, ok with zero slot
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end

         // payload of the entity is back
         S_GET: begin
            rsp_strobe_in  = 1'b1;
            rsp_status_in  = ST_OK;
            rsp_payload_in = pl_rd;
            rsp_slot_in    = slot_ff;
            rsp_count_in   = count_ff;
            state_in       = S_IDLE;
         end

         // last entry moves into the freed slot; its owner points to it
         S_MOVE: begin
            pl_we    = 1'b1;
            pl_wd    = pl_rd;
            eos_we   = 1'b1;
            eos_wd   = eos_rd;
            map_we   = 1'b1;
            map_wa   = eos_rd;
            map_wd   = {1'b1, slot_ff};
            state_in = S_DROP;
         end

         // drop the removed entity's mark last, so removing the tail entry works
         S_DROP: begin
            map_we         = 1'b1;
            map_wa         = ent_ff;
            map_wd         = '0;
            count_in       = count_ff - CNT_W'(1);
            rsp_strobe_in  = 1'b1;
            rsp_status_in  = ST_OK;
            rsp_payload_in = '0;
            rsp_slot_in    = slot_ff;
            rsp_count_in   = count_ff - CNT_W'(1);
            state_in       = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_payload_ff;
   assign rsp_dense_slot  = rsp_slot_ff;
   assign rsp_live_count  = rsp_count_ff;

endmodule
